FILE: rtl/btm_pkg.sv
package btm_pkg;

    localparam int TAPE_CELLS_DEF = 4096;
    localparam int MAX_STATES_DEF = 16;

    localparam int STATE_W  = 4;
    localparam int TICK_W   = 16;
    localparam int CADDR_W  = 12;
    localparam int STEP_W   = 48;
    localparam int OFFSET_W = 12;

    localparam int CMD_W    = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_RULE = 2'd0,
        CMD_START     = 2'd1,
        CMD_ADVANCE   = 2'd2,
        CMD_READ_CELL = 2'd3
    } cmd_t;

    // one transition: next state, symbol written, head move (1 right)
    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic               write_bit;
        logic               direction;
    } rule_t;

    // input item without the command, first field in the highest bits
    typedef struct packed {
        logic [CADDR_W-1:0] cell_address;
        logic [TICK_W-1:0]  tick_count;
        logic               rule_direction;
        logic               rule_write_bit;
        logic [STATE_W-1:0] rule_next_state;
        logic               rule_read_bit;
        logic [STATE_W-1:0] rule_state;
    } item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        logic                cell_bit;
        logic [OFFSET_W-1:0] head_offset;
        logic [STEP_W-1:0]   steps_taken;
        logic                tape_overflow;
        logic                halted;
        logic [STATE_W-1:0]  current_state;
    } status_t;

endpackage

FILE: rtl/btm_tape.sv
module btm_tape
    import btm_pkg::*;
#(
    parameter int TAPE_CELLS = TAPE_CELLS_DEF,
    parameter int HEAD_W     = $clog2(TAPE_CELLS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              wr_en,
    input  logic [HEAD_W-1:0] wr_addr,
    input  logic              wr_bit,
    input  logic [HEAD_W-1:0] rd_addr,
    output logic              rd_bit
);

    logic              mem [TAPE_CELLS];
    logic              mem_q;
    logic              hit_reg;
    logic              hit_next;
    logic              any_reg;
    logic              any_next;
    logic [HEAD_W-1:0] lo_reg;
    logic [HEAD_W-1:0] lo_next;
    logic [HEAD_W-1:0] hi_reg;
    logic [HEAD_W-1:0] hi_next;

    // the head moves one cell per step, so the cells written since the last
    // clear form one interval; anything outside it reads as blank
    always_comb begin
        any_next = any_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (clear) begin
            any_next = 1'b0;
        end else if (wr_en) begin
            any_next = 1'b1;
            if (!any_reg) begin
                lo_next = wr_addr;
                hi_next = wr_addr;
            end else begin
                if (wr_addr < lo_reg) lo_next = wr_addr;
                if (wr_addr > hi_reg) hi_next = wr_addr;
            end
        end
        hit_next = any_reg && (rd_addr >= lo_reg) && (rd_addr <= hi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            any_reg <= any_next;
            hit_reg <= hit_next;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge aclk) begin
        mem_q <= mem[rd_addr];
    end

    assign rd_bit = mem_q & hit_reg;

endmodule

FILE: rtl/btm_rules.sv
module btm_rules
    import btm_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF,
    parameter int RULE_AW    = $clog2(2 * MAX_STATES)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [RULE_AW-1:0] wr_addr,
    input  rule_t              wr_data,
    input  logic [RULE_AW-1:0] rd_addr,
    output rule_t              rd_data
);

    rule_t mem [2 * MAX_STATES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/btm_ctrl.sv
module btm_ctrl
    import btm_pkg::*;
#(
    parameter int TAPE_CELLS = TAPE_CELLS_DEF,
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  cmd_t               item_cmd,
    input  item_t              item,
    input  logic [STATE_W-1:0] start_state,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_free,
    output status_t            status
);

    localparam int HEAD_W  = $clog2(TAPE_CELLS);
    localparam int RULE_AW = $clog2(2 * MAX_STATES);
    localparam int ADDR_W  = ((HEAD_W > CADDR_W) ? HEAD_W : CADDR_W) + 1;
    localparam int DIFF_W  = HEAD_W + 1;
    localparam int OFS_X_W = (DIFF_W > OFFSET_W) ? DIFF_W : OFFSET_W;
    localparam logic [HEAD_W-1:0] MID_CELL  = HEAD_W'(TAPE_CELLS / 2);
    localparam logic [HEAD_W-1:0] LAST_CELL = HEAD_W'(TAPE_CELLS - 1);
    localparam logic [STEP_W-1:0] STEP_MAX  = {STEP_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_CELL,
        S_DONE
    } fsm_t;

    fsm_t               fsm_reg, fsm_next;
    logic [STATE_W-1:0] mstate_reg, mstate_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               ovf_reg, ovf_next;
    logic [TICK_W-1:0]  remain_reg, remain_next;
    logic               cell_in_reg, cell_in_next;
    logic               cell_bit_reg, cell_bit_next;

    logic               tape_clear;
    logic               tape_we;
    logic [HEAD_W-1:0]  tape_raddr;
    logic               tape_bit;
    logic               rule_we;
    logic [RULE_AW-1:0] rule_waddr;
    rule_t              rule_wdata;
    logic [RULE_AW-1:0] rule_raddr;
    rule_t              rule_q;

    logic [ADDR_W-1:0]  cell_addr_ext;
    logic               at_edge;
    logic [HEAD_W-1:0]  step_head;
    logic [TICK_W-1:0]  remain_dec;
    logic               start_acc;
    logic [DIFF_W-1:0]  head_diff;
    logic [OFS_X_W-1:0] head_diff_ext;

    function automatic logic state_ok(input logic [STATE_W-1:0] s);
        state_ok = (32'(s) < 32'(MAX_STATES));
    endfunction

    btm_tape #(
        .TAPE_CELLS (TAPE_CELLS),
        .HEAD_W     (HEAD_W)
    ) u_tape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (tape_clear),
        .wr_en   (tape_we),
        .wr_addr (head_reg),
        .wr_bit  (rule_q.write_bit),
        .rd_addr (tape_raddr),
        .rd_bit  (tape_bit)
    );

    btm_rules #(
        .MAX_STATES (MAX_STATES),
        .RULE_AW    (RULE_AW)
    ) u_rules (
        .aclk    (aclk),
        .wr_en   (rule_we),
        .wr_addr (rule_waddr),
        .wr_data (rule_wdata),
        .rd_addr (rule_raddr),
        .rd_data (rule_q)
    );

    assign cell_addr_ext = ADDR_W'(item.cell_address);
    assign start_acc     = item_valid && (item_cmd == CMD_START);
    assign remain_dec    = remain_reg - TICK_W'(1);

    // head move of the step in flight; at the tape edge the head stays
    always_comb begin
        if (rule_q.direction) begin
            at_edge   = (head_reg == LAST_CELL);
            step_head = head_reg + HEAD_W'(1);
        end else begin
            at_edge   = (head_reg == '0);
            step_head = head_reg - HEAD_W'(1);
        end
        if (at_edge) step_head = head_reg;
    end

    assign rule_raddr = RULE_AW'({mstate_reg, tape_bit});
    assign rule_waddr = RULE_AW'({item.rule_state, item.rule_read_bit});
    assign rule_wdata = '{next_state: item.rule_next_state,
                          write_bit:  item.rule_write_bit,
                          direction:  item.rule_direction};

    always_comb begin
        fsm_next      = fsm_reg;
        mstate_next   = mstate_reg;
        head_next     = head_reg;
        steps_next    = steps_reg;
        ovf_next      = ovf_reg;
        remain_next   = remain_reg;
        cell_in_next  = cell_in_reg;
        cell_bit_next = cell_bit_reg;
        tape_clear    = 1'b0;
        tape_we       = 1'b0;
        tape_raddr    = head_reg;
        rule_we       = 1'b0;

        case (fsm_reg)
            S_IDLE: begin
                if (item_valid) begin
                    cell_bit_next = 1'b0;
                    fsm_next      = S_DONE;
                    case (item_cmd)
                        CMD_LOAD_RULE: begin
                            rule_we = (item.rule_state != '0) && state_ok(item.rule_state);
                        end
                        CMD_START: begin
                            tape_clear  = 1'b1;
                            mstate_next = start_state;
                            head_next   = MID_CELL;
                            steps_next  = '0;
                            ovf_next    = 1'b0;
                        end
                        CMD_ADVANCE: begin
                            remain_next = item.tick_count;
                            if ((item.tick_count != '0) && (mstate_reg != '0) &&
                                !ovf_reg && state_ok(mstate_reg)) begin
                                fsm_next = S_FETCH;
                            end
                        end
                        CMD_READ_CELL: begin
                            tape_raddr   = cell_addr_ext[HEAD_W-1:0];
                            cell_in_next = (cell_addr_ext < ADDR_W'(TAPE_CELLS));
                            fsm_next     = S_CELL;
                        end
                        default: begin
                            fsm_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // tape bit is here, rule lookup goes out
                fsm_next = S_EXEC;
            end
            S_EXEC: begin
                tape_we     = 1'b1;
                mstate_next = rule_q.next_state;
                head_next   = step_head;
                ovf_next    = at_edge;
                remain_next = remain_dec;
                steps_next  = (steps_reg == STEP_MAX) ? steps_reg : steps_reg + STEP_W'(1);
                // next cell read overlaps this write
                tape_raddr  = step_head;
                if ((remain_dec != '0) && (rule_q.next_state != '0) && !at_edge &&
                    state_ok(rule_q.next_state)) begin
                    fsm_next = S_FETCH;
                end else begin
                    fsm_next = S_DONE;
                end
            end
            S_CELL: begin
                cell_bit_next = tape_bit & cell_in_reg;
                fsm_next      = S_DONE;
            end
            S_DONE: begin
                if (result_free) fsm_next = S_IDLE;
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= S_IDLE;
            mstate_reg   <= STATE_W'(1);
            head_reg     <= MID_CELL;
            steps_reg    <= '0;
            ovf_reg      <= 1'b0;
            cell_bit_reg <= 1'b0;
        end else begin
            fsm_reg      <= fsm_next;
            mstate_reg   <= mstate_next;
            head_reg     <= head_next;
            steps_reg    <= steps_next;
            ovf_reg      <= ovf_next;
            cell_bit_reg <= cell_bit_next;
        end
        remain_reg  <= remain_next;
        cell_in_reg <= cell_in_next;
    end

    assign item_ready   = (fsm_reg == S_IDLE);
    assign result_valid = (fsm_reg == S_DONE);

    // signed distance from the middle cell, wrapped to the offset width
    assign head_diff     = {1'b0, head_reg} - {1'b0, MID_CELL};
    assign head_diff_ext = OFS_X_W'(signed'(head_diff));

    assign status.current_state = mstate_reg;
    assign status.halted        = (mstate_reg == '0);
    assign status.tape_overflow = ovf_reg;
    assign status.steps_taken   = steps_reg;
    assign status.head_offset   = head_diff_ext[OFFSET_W-1:0];
    assign status.cell_bit      = cell_bit_reg;

    a_ovf_head_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg && !start_acc |=> $stable(head_reg))
        else $error("head moved while the overflow flag was set");

    a_steps_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !start_acc |=> steps_reg >= $past(steps_reg))
        else $error("step count went down without a start");

    a_head_one_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        !start_acc |=> (head_reg == $past(head_reg)) ||
                       (head_reg == $past(head_reg) + HEAD_W'(1)) ||
                       (head_reg == $past(head_reg) - HEAD_W'(1)))
        else $error("head moved by more than one cell");

    a_write_when_running: assert property (@(posedge aclk) disable iff (!aresetn)
        tape_we |-> !ovf_reg && (mstate_reg != '0) && (remain_reg != '0))
        else $error("tape written outside a running step");

    a_accept_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid |-> (fsm_reg == S_IDLE))
        else $error("transaction taken while busy");

endmodule

FILE: rtl/binary_turing_machine_stepper_top.sv
// Two-symbol Turing machine stepper. Each input transaction carries a command in
// s_tuser (load_rule, start, advance, read_cell) and gives exactly one status
// transaction on the m_ side. One command is worked on at a time. Load_rule and start
// go from the accepting state straight to the done state, read_cell passes through a
// cell read state first, and advance through a fetch and an execute state for each
// machine step it runs. In the done state the block stays busy until the output
// register is free, and then loads the result register. The step loop is a tape
// read followed by a rule table read, with the tape write and head move of a step
// overlapping the tape read of the next one. A command may be accepted while the
// previous result still waits in the output register. The tape needs no clearing
// pass, neither after reset nor on start: the cells written since the last start
// are tracked as one interval around the head path and all other cells read as
// blank. Rule entries read before being loaded return unspecified values.
module binary_turing_machine_stepper_top
    import btm_pkg::*;
#(
    parameter int TAPE_CELLS = TAPE_CELLS_DEF,
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [STATE_W-1:0]  cfg_wr_data,  // start_state

    input  logic                s_tvalid,
    output logic                s_tready,
    // rule_state, rule_read_bit, rule_next_state, rule_write_bit,
    // rule_direction, tick_count, cell_address, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,      // command

    output logic                m_tvalid,
    input  logic                m_tready,
    // current_state, halted, tape_overflow, steps_taken, head_offset,
    // cell_bit, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int ITEM_W   = $bits(item_t);
    localparam int STATUS_W = $bits(status_t);

    logic [STATE_W-1:0]  start_state_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                item_valid;
    logic                result_valid;
    logic                result_free;
    item_t               item;
    status_t             status;

    assign item       = item_t'(s_tdata[ITEM_W-1:0]);
    assign item_valid = s_tvalid && s_tready;
    // output slot is free when empty or being drained this cycle
    assign result_free = !m_tvalid_reg || m_tready;

    btm_ctrl #(
        .TAPE_CELLS (TAPE_CELLS),
        .MAX_STATES (MAX_STATES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item_cmd     (cmd_t'(s_tuser)),
        .item         (item),
        .start_state  (start_state_reg),
        .item_ready   (s_tready),
        .result_valid (result_valid),
        .result_free  (result_free),
        .status       (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= STATE_W'(1);
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) start_state_reg <= cfg_wr_data;
            if (result_valid && result_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (result_valid && result_free) begin
            m_tdata_reg <= M_DATA_W'(status);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed before it was taken");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:STATUS_W] == '0))
        else $error("result padding not zero");

    a_halted_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STATE_W] == (m_tdata[STATE_W-1:0] == '0)))
        else $error("halted flag disagrees with the state");

endmodule
